FILE: rtl/lis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_pkg
// Shared types and constants of the laser ignition sequencer: phase codes,
// register indexes, configuration and sequence state bundles.
// ----------------------------------------------------------------------------
package lis_pkg;

  typedef enum logic [1:0] {
    PH_PULSE = 2'd0,
    PH_PAUSE = 2'd1,
    PH_POLL  = 2'd2,
    PH_DONE  = 2'd3
  } lis_phase_t;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [CFG_ADDR_W-1:0] CFG_PULSE_TICKS   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PAUSE_TICKS   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_POLL_TICKS    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SUM_THRESHOLD = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_ATTEMPTS  = 3'd4;

  localparam logic [23:0] RST_PULSE_TICKS   = 24'd100;
  localparam logic [23:0] RST_PAUSE_TICKS   = 24'd1000;
  localparam logic [23:0] RST_POLL_TICKS    = 24'd1000;
  localparam logic [30:0] RST_SUM_THRESHOLD = 31'd10000;
  localparam logic [7:0]  RST_MAX_ATTEMPTS  = 8'd8;

  localparam logic [30:0] SUM_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [23:0] pulse_ticks;
    logic [23:0] pause_ticks;
    logic [23:0] poll_ticks;
    logic [30:0] sum_threshold;
    logic [7:0]  max_attempts;
  } lis_cfg_t;

  typedef struct packed {
    logic       req;
    logic       running;
    lis_phase_t phase;
    logic       armed;
    logic [7:0] attempts;
    logic [30:0] sum;
    logic       lased;
    logic       pulse;
  } lis_state_t;

endpackage

FILE: rtl/lis_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_step
// Next-state logic of one control tick: request latch, phase entry and
// countdown, saturating magnitude sum, retry decision and abort.
// ----------------------------------------------------------------------------
module lis_step #(
  parameter int TICK_BITS = 24
) (
  input  lis_pkg::lis_cfg_t   cfg,
  input  lis_pkg::lis_state_t st,
  input  logic [TICK_BITS-1:0] tick,
  input  logic                start_req,
  input  logic                stop_req,
  input  logic signed [31:0]  vib_diff,
  output lis_pkg::lis_state_t st_nxt,
  output logic [TICK_BITS-1:0] tick_nxt,
  output logic                done
);

  lis_pkg::lis_phase_t  ph_cur;
  logic [TICK_BITS-1:0] len;
  logic [TICK_BITS-1:0] tick_dec;
  logic [31:0]          mag;
  logic [32:0]          sum_add;
  logic [30:0]          sum_sat;
  logic [7:0]           att_dec;

  // phase in effect at the start of this tick, a fresh start begins with the pulse
  assign ph_cur = ((start_req || st.req) && !st.running) ? lis_pkg::PH_PULSE : st.phase;

  // phase length of the current phase, sized to the counter
  always_comb begin
    case (ph_cur)
      lis_pkg::PH_PULSE: len = TICK_BITS'(cfg.pulse_ticks);
      lis_pkg::PH_PAUSE: len = TICK_BITS'(cfg.pause_ticks);
      default:           len = TICK_BITS'(cfg.poll_ticks);
    endcase
  end

  assign tick_dec = tick - TICK_BITS'(1);
  // magnitude; the most negative sample maps to 2^31
  assign mag      = vib_diff[31] ? (~vib_diff + 32'd1) : vib_diff;
  assign sum_add  = {2'b00, st.sum} + {1'b0, mag};
  assign sum_sat  = (sum_add[32] || sum_add[31]) ? lis_pkg::SUM_MAX : sum_add[30:0];

  always_comb begin
    st_nxt   = st;
    tick_nxt = tick;
    done     = 1'b0;
    att_dec  = 8'd0;

    if (start_req) begin
      st_nxt.req = 1'b1;
    end

    if (st_nxt.req) begin
      if (!st.running) begin
        st_nxt.attempts = cfg.max_attempts;
        st_nxt.armed    = 1'b0;
        st_nxt.phase    = lis_pkg::PH_PULSE;
        st_nxt.running  = 1'b1;
      end

      if (st_nxt.phase != lis_pkg::PH_DONE) begin
        if (!st_nxt.armed) begin
          // phase entry tick
          tick_nxt     = len;
          st_nxt.armed = 1'b1;
          if (st_nxt.phase == lis_pkg::PH_PULSE) begin
            st_nxt.pulse = 1'b1;
          end
          if (st_nxt.phase == lis_pkg::PH_POLL) begin
            st_nxt.sum = 31'd0;
          end
        end else begin
          if (st_nxt.phase == lis_pkg::PH_POLL) begin
            st_nxt.sum = sum_sat;
          end
          tick_nxt = tick_dec;
          if (tick_dec == '0) begin
            st_nxt.armed = 1'b0;
            st_nxt.phase = lis_pkg::lis_phase_t'(st_nxt.phase + 2'd1);
            if (st_nxt.phase == lis_pkg::PH_PAUSE) begin
              st_nxt.pulse = 1'b0;
            end else if (st_nxt.phase == lis_pkg::PH_DONE) begin
              if (st_nxt.sum >= cfg.sum_threshold) begin
                st_nxt.lased = 1'b1;
              end else begin
                att_dec = (st_nxt.attempts != 8'd0) ? (st_nxt.attempts - 8'd1) : 8'd0;
                st_nxt.attempts = att_dec;
                if (att_dec != 8'd0) begin
                  st_nxt.phase = lis_pkg::PH_PULSE;
                end
              end
            end
          end
        end
      end else begin
        st_nxt.armed = 1'b0;
      end

      if (!st_nxt.armed && st_nxt.phase == lis_pkg::PH_DONE) begin
        st_nxt.req     = 1'b0;
        st_nxt.running = 1'b0;
        st_nxt.pulse   = 1'b0;
        done           = 1'b1;
      end
    end

    // abort
    if (stop_req) begin
      st_nxt.running = 1'b0;
      st_nxt.req     = 1'b0;
      st_nxt.pulse   = 1'b0;
      st_nxt.armed   = 1'b0;
      st_nxt.lased   = 1'b0;
    end
  end

endmodule

FILE: rtl/laser_ignition_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laser_ignition_sequencer
// Laser start-up sequencer: ignition pulse, pause and polling window with
// retries, one control tick per input transaction.
// ----------------------------------------------------------------------------
// Each input transaction is one control tick and yields exactly one result
// transaction. The block takes one transaction per clock: the whole tick is
// evaluated combinationally between the sequence state registers and the
// output register, and the result appears on the clock after acceptance.
// A new transaction is taken while the output register is empty or being
// drained, so throughput is one per clock whenever out_ready stays high.
// Configuration registers may be written only while no transaction is in
// flight.
module laser_ignition_sequencer #(
  parameter int TICK_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lis_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [lis_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_start_req,
  input  logic                              in_stop_req,
  input  logic signed [31:0]                in_vib_diff,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_lightup_drive,
  output logic                              out_backlight_drive,
  output logic                              out_sequence_active,
  output logic                              out_lasing,
  output logic [7:0]                        out_attempts_left,
  output logic [1:0]                        out_phase,
  output logic                              out_done_res
);

  lis_pkg::lis_cfg_t    cfg_r;
  lis_pkg::lis_state_t  st_r;
  lis_pkg::lis_state_t  st_nxt;
  logic [TICK_BITS-1:0] tick_r;
  logic [TICK_BITS-1:0] tick_nxt;
  logic                 done_nxt;
  logic                 out_valid_r;
  logic                 done_r;
  logic                 in_acc;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_ticks   <= lis_pkg::RST_PULSE_TICKS;
      cfg_r.pause_ticks   <= lis_pkg::RST_PAUSE_TICKS;
      cfg_r.poll_ticks    <= lis_pkg::RST_POLL_TICKS;
      cfg_r.sum_threshold <= lis_pkg::RST_SUM_THRESHOLD;
      cfg_r.max_attempts  <= lis_pkg::RST_MAX_ATTEMPTS;
    end else if (cfg_we) begin
      case (cfg_addr)
        lis_pkg::CFG_PULSE_TICKS:   cfg_r.pulse_ticks   <= cfg_wdata[23:0];
        lis_pkg::CFG_PAUSE_TICKS:   cfg_r.pause_ticks   <= cfg_wdata[23:0];
        lis_pkg::CFG_POLL_TICKS:    cfg_r.poll_ticks    <= cfg_wdata[23:0];
        lis_pkg::CFG_SUM_THRESHOLD: cfg_r.sum_threshold <= cfg_wdata[30:0];
        lis_pkg::CFG_MAX_ATTEMPTS:  cfg_r.max_attempts  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  lis_step #(
    .TICK_BITS (TICK_BITS)
  ) u_step (
    .cfg       (cfg_r),
    .st        (st_r),
    .tick      (tick_r),
    .start_req (in_start_req),
    .stop_req  (in_stop_req),
    .vib_diff  (in_vib_diff),
    .st_nxt    (st_nxt),
    .tick_nxt  (tick_nxt),
    .done      (done_nxt)
  );

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      tick_r <= '0;
    end else if (in_acc) begin
      st_r   <= st_nxt;
      tick_r <= tick_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      done_r <= done_nxt;
    end
  end

  // result fields follow the registered state of the last tick
  assign out_lightup_drive   = st_r.pulse;
  assign out_backlight_drive = st_r.running;
  assign out_sequence_active = st_r.running;
  assign out_lasing          = st_r.lased;
  assign out_attempts_left   = st_r.attempts;
  assign out_phase           = st_r.phase;
  assign out_done_res        = done_r;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the laser ignition sequencer. Control ticks go in
// over a valid/ready channel and a tick-accurate model of the start-up
// sequence predicts every result transaction. Directed cases cover sum
// saturation, a start request on the final tick, a single attempt, aborts
// and extreme phase lengths. Random sequences run under several register
// settings with random stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int HOLD_CYCLES = 60;
  localparam int STALL_LIMIT = 1000;
  localparam int MAX_PRINTS  = 100;

  typedef struct packed {
    logic                lightup;
    logic                backlight;
    logic                active;
    logic                lasing;
    logic [7:0]          attempts_left;
    lis_pkg::lis_phase_t phase;
    logic                done;
  } tick_result_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [lis_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [lis_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_valid;
  logic                           in_ready;
  logic                           in_start_req;
  logic                           in_stop_req;
  logic signed [31:0]             in_vib_diff;
  logic                           out_valid;
  logic                           out_ready;
  logic                           out_lightup_drive;
  logic                           out_backlight_drive;
  logic                           out_sequence_active;
  logic                           out_lasing;
  logic [7:0]                     out_attempts_left;
  logic [1:0]                     out_phase;
  logic                           out_done_res;

  // sequence model state
  lis_pkg::lis_cfg_t   cfg;
  logic                req_latched;
  logic                seq_running;
  lis_pkg::lis_phase_t ph_idx;
  logic                ph_armed;
  logic [23:0]         ticks_left;
  logic [7:0]          attempts;
  logic [30:0]         vib_sum;
  logic                lased;
  logic                pulse;

  tick_result_t tick_q[$];
  int           mismatches;
  int           in_idle_pct;
  int           out_idle_pct;
  logic         hold_req;
  int           stall_cycles;

  laser_ignition_sequencer i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_addr            (cfg_addr),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_start_req        (in_start_req),
    .in_stop_req         (in_stop_req),
    .in_vib_diff         (in_vib_diff),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_lightup_drive   (out_lightup_drive),
    .out_backlight_drive (out_backlight_drive),
    .out_sequence_active (out_sequence_active),
    .out_lasing          (out_lasing),
    .out_attempts_left   (out_attempts_left),
    .out_phase           (out_phase),
    .out_done_res        (out_done_res)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("ERROR: %0t %s got %0h expected %0h", $time, what, got, want);
  endtask

  // advance the sequence model by one tick and queue its result
  task automatic predict_tick(input logic start, input logic stop, input logic [31:0] vib);
    logic [32:0]  mag;
    logic [32:0]  total;
    logic         ended;
    tick_result_t r;
    ended = 1'b0;
    if (start) req_latched = 1'b1;
    if (req_latched) begin
      if (!seq_running) begin
        attempts    = cfg.max_attempts;
        ph_armed    = 1'b0;
        ph_idx      = lis_pkg::PH_PULSE;
        seq_running = 1'b1;
      end
      if (ph_idx != lis_pkg::PH_DONE) begin
        if (!ph_armed) begin
          case (ph_idx)
            lis_pkg::PH_PULSE: ticks_left = cfg.pulse_ticks;
            lis_pkg::PH_PAUSE: ticks_left = cfg.pause_ticks;
            default:           ticks_left = cfg.poll_ticks;
          endcase
          ph_armed = 1'b1;
          if (ph_idx == lis_pkg::PH_PULSE) pulse = 1'b1;
          if (ph_idx == lis_pkg::PH_POLL) vib_sum = '0;
        end else begin
          if (ph_idx == lis_pkg::PH_POLL) begin
            mag     = {1'b0, (vib[31] ? (~vib + 32'd1) : vib)};
            total   = {2'b00, vib_sum} + mag;
            vib_sum = (total > {2'b00, lis_pkg::SUM_MAX}) ? lis_pkg::SUM_MAX : total[30:0];
          end
          ticks_left = ticks_left - 24'd1;
          if (ticks_left == 24'd0) begin
            ph_armed = 1'b0;
            ph_idx   = lis_pkg::lis_phase_t'(ph_idx + 2'd1);
            if (ph_idx == lis_pkg::PH_PAUSE) begin
              pulse = 1'b0;
            end else if (ph_idx == lis_pkg::PH_DONE) begin
              if (vib_sum >= cfg.sum_threshold) begin
                lased = 1'b1;
              end else begin
                if (attempts != 8'd0) attempts = attempts - 8'd1;
                if (attempts != 8'd0) ph_idx = lis_pkg::PH_PULSE;
              end
            end
          end
        end
      end else begin
        ph_armed = 1'b0;
      end
      if (!ph_armed && ph_idx == lis_pkg::PH_DONE) begin
        req_latched = 1'b0;
        seq_running = 1'b0;
        pulse       = 1'b0;
        ended       = 1'b1;
      end
    end
    if (stop) begin
      seq_running = 1'b0;
      req_latched = 1'b0;
      pulse       = 1'b0;
      ph_armed    = 1'b0;
      lased       = 1'b0;
    end
    r.lightup       = pulse;
    r.backlight     = seq_running;
    r.active        = seq_running;
    r.lasing        = lased;
    r.attempts_left = attempts;
    r.phase         = ph_idx;
    r.done          = ended;
    tick_q.push_back(r);
  endtask

  // offer one tick; valid stays high on return unless the next call idles
  task automatic send_tick(input logic start, input logic stop, input logic [31:0] vib);
    int gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_start_req <= start;
    in_stop_req  <= stop;
    in_vib_diff  <= vib;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tick(start, stop, vib);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tick_q.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lis_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [lis_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      lis_pkg::CFG_PULSE_TICKS:   cfg.pulse_ticks   = data[23:0];
      lis_pkg::CFG_PAUSE_TICKS:   cfg.pause_ticks   = data[23:0];
      lis_pkg::CFG_POLL_TICKS:    cfg.poll_ticks    = data[23:0];
      lis_pkg::CFG_SUM_THRESHOLD: cfg.sum_threshold = data[30:0];
      lis_pkg::CFG_MAX_ATTEMPTS:  cfg.max_attempts  = data[7:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [23:0] pulse_len, input logic [23:0] pause_len,
                             input logic [23:0] poll_len, input logic [30:0] threshold,
                             input logic [7:0] tries);
    write_reg(lis_pkg::CFG_PULSE_TICKS, {7'd0, pulse_len});
    write_reg(lis_pkg::CFG_PAUSE_TICKS, {7'd0, pause_len});
    write_reg(lis_pkg::CFG_POLL_TICKS, {7'd0, poll_len});
    write_reg(lis_pkg::CFG_SUM_THRESHOLD, threshold);
    write_reg(lis_pkg::CFG_MAX_ATTEMPTS, {23'd0, tries});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_vib();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3, 4: return $urandom;
      default: return $urandom_range(2000) - 32'd1000;
    endcase
  endfunction

  task automatic run_random_ticks(input int count);
    logic start;
    for (int i = 0; i < count; i++) begin
      start = seq_running ? ($urandom_range(99) < 4) : ($urandom_range(99) < 40);
      send_tick(start, $urandom_range(99) < 2, pick_vib());
    end
  endtask

  // saturating sum hits the top threshold; start on the last tick is swallowed
  task automatic test_saturation_and_final_request();
    load_config(24'd1, 24'd1, 24'd2, lis_pkg::SUM_MAX, 8'd1);
    send_tick(1'b1, 1'b0, 32'd0);
    repeat (3) send_tick(1'b0, 1'b0, 32'd0);
    send_tick(1'b0, 1'b0, 32'h0000_1234);
    send_tick(1'b0, 1'b0, 32'h8000_0000);
    send_tick(1'b1, 1'b0, 32'h7FFF_FFFF);
    send_tick(1'b0, 1'b0, 32'hFFFF_FFFF);
    drain();
  endtask

  // zero attempts act as one; the single poll ends below the threshold
  task automatic test_single_attempt();
    load_config(24'd1, 24'd1, 24'd1, 31'd5, 8'd0);
    send_tick(1'b1, 1'b0, 32'd0);
    repeat (4) send_tick(1'b0, 1'b0, 32'hFFFF_FFFF);
    send_tick(1'b0, 1'b0, 32'd4);
    send_tick(1'b0, 1'b0, 32'd0);
    drain();
  endtask

  task automatic test_abort();
    load_config(24'd2, 24'd1, 24'd1, 31'd0, 8'd1);
    send_tick(1'b1, 1'b1, 32'd7);
    send_tick(1'b1, 1'b0, 32'd0);
    repeat (2) send_tick(1'b0, 1'b0, 32'h5555_5555);
    send_tick(1'b0, 1'b1, 32'hAAAA_AAAA);
    send_tick(1'b0, 1'b1, 32'd0);
    drain();
  endtask

  // zero length wraps the counter; full-scale lengths only start counting
  task automatic test_phase_length_extremes();
    load_config(24'd0, 24'd0, 24'd0, 31'd0, 8'd255);
    send_tick(1'b1, 1'b0, 32'd0);
    repeat (3) send_tick(1'b0, 1'b0, 32'd1);
    send_tick(1'b0, 1'b1, 32'd0);
    drain();
    load_config(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, lis_pkg::SUM_MAX, 8'd255);
    send_tick(1'b1, 1'b0, 32'd0);
    repeat (3) send_tick(1'b0, 1'b0, 32'd1);
    send_tick(1'b0, 1'b1, 32'd0);
    drain();
  endtask

  task automatic test_backpressure();
    load_config(24'd2, 24'd1, 24'd3, 31'd1500, 8'd3);
    hold_req = 1'b1;
    run_random_ticks(40);
    drain();
  endtask

  task automatic test_random_sequences();
    logic [30:0] thr;
    logic [7:0]  tries;
    for (int r = 0; r < 6; r++) begin
      in_idle_pct  = (r == 0) ? 0 : 22;
      out_idle_pct = (r == 0) ? 0 : 22;
      case ($urandom_range(3))
        0:       thr = 31'd0;
        1:       thr = 31'($urandom_range(5000));
        2:       thr = 31'($urandom);
        default: thr = lis_pkg::SUM_MAX;
      endcase
      tries = (r == 5) ? 8'd255 : 8'($urandom_range(4));
      load_config(24'($urandom_range(1, 4)), 24'($urandom_range(1, 4)),
                  24'($urandom_range(1, 6)), thr, tries);
      run_random_ticks(95);
      drain();
    end
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    tick_result_t got;
    tick_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_lightup_drive, out_backlight_drive, out_sequence_active, out_lasing,
             out_attempts_left, out_phase, out_done_res};
      if (tick_q.size() == 0) begin
        report_mismatch("unexpected transaction", 32'(got), '0);
      end else begin
        want = tick_q.pop_front();
        if (got.lightup !== want.lightup)
          report_mismatch("lightup_drive", 32'(got.lightup), 32'(want.lightup));
        if (got.backlight !== want.backlight)
          report_mismatch("backlight_drive", 32'(got.backlight), 32'(want.backlight));
        if (got.active !== want.active)
          report_mismatch("sequence_active", 32'(got.active), 32'(want.active));
        if (got.lasing !== want.lasing)
          report_mismatch("lasing", 32'(got.lasing), 32'(want.lasing));
        if (got.attempts_left !== want.attempts_left)
          report_mismatch("attempts_left", 32'(got.attempts_left),
                          32'(want.attempts_left));
        if (got.phase !== want.phase)
          report_mismatch("phase", 32'(got.phase), 32'(want.phase));
        if (got.done !== want.done)
          report_mismatch("done_res", 32'(got.done), 32'(want.done));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_start_req = 1'b0;
    in_stop_req  = 1'b0;
    in_vib_diff  = '0;
    hold_req     = 1'b0;
    stall_cycles = 0;
    mismatches   = 0;
    in_idle_pct  = 22;
    out_idle_pct = 22;
    cfg          = {lis_pkg::RST_PULSE_TICKS, lis_pkg::RST_PAUSE_TICKS,
                    lis_pkg::RST_POLL_TICKS, lis_pkg::RST_SUM_THRESHOLD,
                    lis_pkg::RST_MAX_ATTEMPTS};
    req_latched  = 1'b0;
    seq_running  = 1'b0;
    ph_idx       = lis_pkg::PH_PULSE;
    ph_armed     = 1'b0;
    ticks_left   = '0;
    attempts     = '0;
    vib_sum      = '0;
    lased        = 1'b0;
    pulse        = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_saturation_and_final_request();
    test_single_attempt();
    test_abort();
    test_phase_length_extremes();
    test_backpressure();
    test_random_sequences();

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && tick_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lis_pkg.sv
rtl/lis_step.sv
rtl/laser_ignition_sequencer.sv
tb/sv/tb.sv
